FILE: hdl/itt_pkg.sv
package itt_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int ID_W        = 16;
  localparam int WORD_W      = 32;
  localparam int PARAMS      = 4;
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
  localparam int VCNT_W      = 5;

  localparam logic [1:0] REQ_SET  = 2'd0;
  localparam logic [1:0] REQ_STOP = 2'd1;
  localparam logic [1:0] REQ_ACT  = 2'd2;
  localparam logic [1:0] REQ_TICK = 2'd3;

  localparam logic [1:0] KIND_FIRE    = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ACK     = 2'd2;

  typedef logic [PARAMS-1:0][WORD_W-1:0] params_t;

  // operation carried along the chain during one pass
  typedef enum logic [2:0] {
    OP_STOP,
    OP_ACT,
    OP_SET,
    OP_ALLOC,
    OP_TICK
  } op_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ID_W-1:0]   timer_id;
    logic [WORD_W-1:0] interval;
    logic [WORD_W-1:0] now_ms;
    logic              active_flag;
    logic              has_params;
    logic [WORD_W-1:0] param_a;
    logic [WORD_W-1:0] param_b;
    logic [WORD_W-1:0] param_c;
    logic [WORD_W-1:0] param_d;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   fired_id;
    logic [WORD_W-1:0] out_param_a;
    logic [WORD_W-1:0] out_param_b;
    logic [WORD_W-1:0] out_param_c;
    logic [WORD_W-1:0] out_param_d;
    logic [VCNT_W-1:0] valid_count;
    logic              found;
    logic              table_full;
    logic              last;
  } out_item_t;

  // request held steady and seen by every cell during a pass
  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   timer_id;
    logic [WORD_W-1:0] interval;
    logic [WORD_W-1:0] now_ms;
    logic              active_flag;
    params_t           params;
  } cmd_t;

  // token handed from cell to cell
  typedef struct packed {
    logic             v;
    logic             found;
    logic [CNT_W-1:0] cnt;
  } tok_t;

  typedef struct packed {
    logic            req;
    logic [ID_W-1:0] id;
    params_t         params;
  } fire_t;

endpackage

FILE: hdl/itt_in_if.sv
interface itt_in_if;
  import itt_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/itt_out_if.sv
interface itt_out_if;
  import itt_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/itt_cell.sv
module itt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  itt_pkg::cmd_t  cmd,
  input  itt_pkg::tok_t  tok_in,
  input  logic          stall,
  output itt_pkg::tok_t  tok_out,
  output itt_pkg::fire_t fire
);
  import itt_pkg::*;

  logic              used_r;
  logic [ID_W-1:0]   id_r;
  logic              valid_r;
  logic              active_r;
  logic [WORD_W-1:0] interval_r;
  logic [WORD_W-1:0] last_r;
  params_t           params_r;
  tok_t              tok_r;

  logic              search;
  logic              hit;
  logic              claim;
  logic              tick_live;
  logic              fire_req;
  logic [WORD_W-1:0] elapsed;
  tok_t              tok_nxt;

  assign search    = (cmd.op == OP_STOP) || (cmd.op == OP_ACT) || (cmd.op == OP_SET);
  // only the first matching slot along the chain takes the request
  assign hit       = tok_in.v && search && used_r && (id_r == cmd.timer_id) && !tok_in.found;
  assign claim     = tok_in.v && (cmd.op == OP_ALLOC) && !used_r && !tok_in.found;
  assign tick_live = tok_in.v && (cmd.op == OP_TICK) && used_r && active_r;
  assign elapsed   = cmd.now_ms - last_r;
  assign fire_req  = tick_live && valid_r && (elapsed > interval_r);

  always_comb begin
    tok_nxt       = tok_in;
    tok_nxt.found = tok_in.found | hit | claim;
    if (tick_live && valid_r) begin
      tok_nxt.cnt = tok_in.cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.v <= 1'b0;
      used_r  <= 1'b0;
    end else if (!stall) begin
      tok_r <= tok_nxt;
      if (claim) begin
        used_r <= 1'b1;
      end else if (tick_live && !valid_r) begin
        used_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      if (hit) begin
        unique case (cmd.op)
          OP_STOP: valid_r  <= 1'b0;
          OP_ACT:  active_r <= cmd.active_flag;
          OP_SET: begin
            valid_r    <= 1'b1;
            interval_r <= cmd.interval;
            last_r     <= cmd.now_ms;
            params_r   <= cmd.params;
          end
          default: ;
        endcase
      end
      if (claim) begin
        id_r       <= cmd.timer_id;
        active_r   <= 1'b1;
        valid_r    <= 1'b1;
        interval_r <= cmd.interval;
        last_r     <= cmd.now_ms;
        params_r   <= cmd.params;
      end
      if (fire_req) begin
        last_r <= cmd.now_ms;
      end
    end
  end

  assign tok_out     = tok_r;
  assign fire.req    = fire_req;
  assign fire.id     = fire_req ? id_r : '0;
  assign fire.params = fire_req ? params_r : '0;

endmodule

FILE: hdl/interval_timer_table.sv
// interval_timer_table: table of TIMER_SLOTS periodic timers held in a row of cells
// input channel in_chan takes one request word: set, stop, activate or tick
// output channel out_chan gives the result words of each request in order,
// the final one of every request marked by last
// a request launches a token at cell 0 that moves one cell per cycle unless the
// chain is held; each cell acts on its own slot as the token passes
// stop, activate and set of a known id: one pass along the chain per request
// set of a new id: a second pass allocates a free slot
// tick: one pass, each fire word leaves as the token reaches
// its cell, then the summary word follows
// one request is in the chain at a time
// a result word waits in the output register while the next request is taken
// when the receiver stalls with a fire word pending, the whole chain holds
// until the word is taken
// synchronous reset frees every slot and empties the chain and output register
module interval_timer_table (
  input  logic      clk,
  input  logic      rst_n,
  itt_in_if.sink    in_chan,
  itt_out_if.source out_chan
);
  import itt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  state_t           state_r;
  cmd_t             cmd_r;
  logic             launch_r;
  logic             fin_found_r;
  logic [CNT_W-1:0] fin_cnt_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             launch_nxt;
  logic             out_valid_nxt;
  out_item_t        out_data_nxt;

  tok_t             tok [TIMER_SLOTS+1];
  fire_t            fire [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] fire_vec;
  logic [TIMER_SLOTS-1:0] tok_vec;
  fire_t            fire_sel;
  logic             fire_any;
  logic             out_can_load;
  logic             stall;
  logic             in_acc;
  cmd_t             cmd_new;

  assign tok[0] = '{v: launch_r, found: 1'b0, cnt: '0};

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    itt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd_r),
      .tok_in (tok[i]),
      .stall  (stall),
      .tok_out(tok[i+1]),
      .fire   (fire[i])
    );
    assign fire_vec[i] = fire[i].req;
    assign tok_vec[i]  = tok[i+1].v;
  end

  // at most one cell holds the token, so an or over the cells selects it
  always_comb begin
    fire_sel = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      fire_sel = fire_sel | fire[i];
    end
  end

  assign fire_any     = |fire_vec;
  assign out_can_load = !out_valid_r || out_chan.ready;
  assign stall        = fire_any && !out_can_load;
  assign in_acc       = in_chan.valid && in_chan.ready;

  always_comb begin
    cmd_new.timer_id    = in_chan.data.timer_id;
    cmd_new.interval    = in_chan.data.interval;
    cmd_new.now_ms      = in_chan.data.now_ms;
    cmd_new.active_flag = in_chan.data.active_flag;
    cmd_new.params      = in_chan.data.has_params ?
                          {in_chan.data.param_d, in_chan.data.param_c,
                           in_chan.data.param_b, in_chan.data.param_a} : '1;
    unique case (in_chan.data.req_type)
      REQ_TICK: cmd_new.op = OP_TICK;
      REQ_STOP: cmd_new.op = OP_STOP;
      REQ_ACT:  cmd_new.op = OP_ACT;
      REQ_SET:  cmd_new.op = (in_chan.data.interval == '0) ? OP_STOP : OP_SET;
      default:  cmd_new.op = OP_STOP;
    endcase
  end

  // a token held at cell 0 by a stall keeps launch_r up
  always_comb begin
    launch_nxt    = launch_r && stall;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          launch_nxt = 1'b1;
        end
      end
      ST_RUN: begin
        if (fire_any && out_can_load) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt             = '0;
          out_data_nxt.kind        = KIND_FIRE;
          out_data_nxt.fired_id    = fire_sel.id;
          out_data_nxt.out_param_a = fire_sel.params[0];
          out_data_nxt.out_param_b = fire_sel.params[1];
          out_data_nxt.out_param_c = fire_sel.params[2];
          out_data_nxt.out_param_d = fire_sel.params[3];
        end
        if (tok[TIMER_SLOTS].v && (cmd_r.op == OP_SET) && !tok[TIMER_SLOTS].found) begin
          launch_nxt = 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_can_load) begin
          out_valid_nxt     = 1'b1;
          out_data_nxt      = '0;
          out_data_nxt.last = 1'b1;
          priority if (cmd_r.op == OP_TICK) begin
            out_data_nxt.kind        = KIND_SUMMARY;
            out_data_nxt.valid_count = VCNT_W'(fin_cnt_r);
          end else if (cmd_r.op == OP_ALLOC) begin
            out_data_nxt.kind       = KIND_ACK;
            out_data_nxt.table_full = !fin_found_r;
          end else begin
            out_data_nxt.kind  = KIND_ACK;
            out_data_nxt.found = fin_found_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_r   <= cmd_new;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (tok[TIMER_SLOTS].v) begin
            if ((cmd_r.op == OP_SET) && !tok[TIMER_SLOTS].found) begin
              cmd_r.op <= OP_ALLOC;
            end else begin
              fin_found_r <= tok[TIMER_SLOTS].found;
              fin_cnt_r   <= tok[TIMER_SLOTS].cnt;
              state_r     <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (out_can_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({launch_r, tok_vec}))
    else $error("more than one token in the chain");

  a_one_fire: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(fire_vec))
    else $error("several cells fire at once");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable({launch_r, tok_vec}))
    else $error("token moved while the chain was held");

  a_no_fire_outside_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> !fire_any)
    else $error("fire outside a pass");

  a_token_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !(launch_r || (|tok_vec)))
    else $error("token alive while idle");
`endif

endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import itt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 96;

  typedef struct {
    in_item_t  item;
    int        rep;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  itt_in_if  in_chan ();
  itt_out_if out_chan ();

  interval_timer_table u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // own copy of the timer table
  logic        tt_used  [TIMER_SLOTS];
  logic [15:0] tt_id    [TIMER_SLOTS];
  logic        tt_valid [TIMER_SLOTS];
  logic        tt_active[TIMER_SLOTS];
  logic [31:0] tt_ivl   [TIMER_SLOTS];
  logic [31:0] tt_start [TIMER_SLOTS];
  logic [31:0] tt_param [TIMER_SLOTS][4];

  out_item_t   req_words[$];
  out_item_t   pending_words[$];
  int          fail_count   = 0;
  int          cycle_count  = 0;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int          hold_len     = 0;
  logic [31:0] clock_ms;
  logic [15:0] id_pool[POOL_SIZE];

  // works out the result words one request gives and updates the table
  function automatic void serve_request(in_item_t x);
    int          i;
    int          s;
    int          cnt;
    logic [31:0] elapsed;
    out_item_t   r;
    req_words.delete();
    if (x.req_type == REQ_TICK) begin
      cnt = 0;
      for (i = 0; i < TIMER_SLOTS; i++) begin
        if (!tt_used[i] || !tt_active[i]) continue;
        if (!tt_valid[i]) begin
          tt_used[i] = 1'b0;
          continue;
        end
        cnt++;
        elapsed = x.now_ms - tt_start[i];
        if (elapsed > tt_ivl[i]) begin
          r = '0;
          r.kind        = KIND_FIRE;
          r.fired_id    = tt_id[i];
          r.out_param_a = tt_param[i][0];
          r.out_param_b = tt_param[i][1];
          r.out_param_c = tt_param[i][2];
          r.out_param_d = tt_param[i][3];
          req_words.insert(req_words.size(), r);
          tt_start[i] = x.now_ms;
        end
      end
      r = '0;
      r.kind        = KIND_SUMMARY;
      r.valid_count = cnt[4:0];
      r.last        = 1'b1;
      req_words.insert(req_words.size(), r);
      return;
    end
    s = -1;
    for (i = 0; i < TIMER_SLOTS; i++)
      if (s < 0 && tt_used[i] && tt_id[i] == x.timer_id) s = i;
    r = '0;
    r.kind  = KIND_ACK;
    r.last  = 1'b1;
    r.found = (s >= 0);
    if (x.req_type == REQ_STOP || (x.req_type == REQ_SET && x.interval == '0)) begin
      if (s >= 0) tt_valid[s] = 1'b0;
    end else if (x.req_type == REQ_ACT) begin
      if (s >= 0) tt_active[s] = x.active_flag;
    end else begin
      if (s < 0) begin
        for (i = 0; i < TIMER_SLOTS; i++)
          if (s < 0 && !tt_used[i]) s = i;
        if (s < 0) begin
          r.table_full = 1'b1;
          req_words.insert(req_words.size(), r);
          return;
        end
        tt_used[s]   = 1'b1;
        tt_id[s]     = x.timer_id;
        tt_active[s] = 1'b1;
      end
      tt_valid[s] = 1'b1;
      tt_ivl[s]   = x.interval;
      tt_start[s] = x.now_ms;
      tt_param[s][0] = x.has_params ? x.param_a : 32'hFFFF_FFFF;
      tt_param[s][1] = x.has_params ? x.param_b : 32'hFFFF_FFFF;
      tt_param[s][2] = x.has_params ? x.param_c : 32'hFFFF_FFFF;
      tt_param[s][3] = x.has_params ? x.param_d : 32'hFFFF_FFFF;
    end
    req_words.insert(req_words.size(), r);
  endfunction

  function automatic dir_row_t drow(logic [1:0] req, logic [15:0] id, logic [31:0] ivl,
                                    logic [31:0] now, logic act, logic hasp,
                                    logic [31:0] pa, logic [31:0] pb, logic [31:0] pc,
                                    logic [31:0] pd, int rep, bit typed, logic [1:0] kind,
                                    logic [4:0] cnt, logic fnd, logic full);
    dir_row_t d;
    d.item.req_type    = req;
    d.item.timer_id    = id;
    d.item.interval    = ivl;
    d.item.now_ms      = now;
    d.item.active_flag = act;
    d.item.has_params  = hasp;
    d.item.param_a     = pa;
    d.item.param_b     = pb;
    d.item.param_c     = pc;
    d.item.param_d     = pd;
    d.rep              = rep;
    d.typed            = typed;
    d.res              = '0;
    d.res.kind         = kind;
    d.res.valid_count  = cnt;
    d.res.found        = fnd;
    d.res.table_full   = full;
    d.res.last         = 1'b1;
    return d;
  endfunction

  function automatic in_item_t random_request();
    in_item_t x;
    int       pick;
    int       r;
    x.timer_id    = ($urandom_range(19) == 0) ? 16'($urandom) :
                    id_pool[$urandom_range(POOL_SIZE-1)];
    x.interval    = $urandom;
    x.now_ms      = $urandom;
    x.active_flag = 1'($urandom_range(1));
    x.has_params  = 1'($urandom_range(1));
    x.param_a     = $urandom;
    x.param_b     = $urandom;
    x.param_c     = $urandom;
    x.param_d     = $urandom;
    if ($urandom_range(99) < 3) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(60);
    pick = $urandom_range(99);
    if (pick < 38) begin
      x.req_type = REQ_SET;
      x.now_ms   = clock_ms;
      r = $urandom_range(99);
      if (r < 8) x.interval = '0;
      else if (r < 17) x.interval = 32'hFFFF_FFFF;
      else if (r >= 23) x.interval = $urandom_range(150, 1);
    end else if (pick < 52) begin
      x.req_type = REQ_STOP;
    end else if (pick < 65) begin
      x.req_type    = REQ_ACT;
      x.active_flag = ($urandom_range(9) < 7);
    end else begin
      x.req_type = REQ_TICK;
      x.now_ms   = clock_ms;
    end
    return x;
  endfunction

  task automatic send_word(in_item_t x, bit typed, out_item_t typed_res);
    int gap;
    gap = 0;
    if (hold_len == 0)
      while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= x;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    serve_request(x);
    if (typed) pending_words.insert(pending_words.size(), typed_res);
    else foreach (req_words[i]) pending_words.insert(pending_words.size(), req_words[i]);
  endtask

  function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // result channel: random stalls, plus one long hold-off
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_chan.ready <= 1'b0;
        hold_len--;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = out_chan.data;
      if (pending_words.size() == 0) begin
        $error("unexpected word: kind %0h id %0h", got.kind, got.fired_id);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        cmp_field("kind", 32'(want.kind), 32'(got.kind));
        cmp_field("fired_id", 32'(want.fired_id), 32'(got.fired_id));
        cmp_field("out_param_a", want.out_param_a, got.out_param_a);
        cmp_field("out_param_b", want.out_param_b, got.out_param_b);
        cmp_field("out_param_c", want.out_param_c, got.out_param_c);
        cmp_field("out_param_d", want.out_param_d, got.out_param_d);
        cmp_field("valid_count", 32'(want.valid_count), 32'(got.valid_count));
        cmp_field("found", 32'(want.found), 32'(got.found));
        cmp_field("table_full", 32'(want.table_full), 32'(got.table_full));
        cmp_field("last", 32'(want.last), 32'(got.last));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("interval_timer_table regression: fail");
    $finish;
  end

  initial begin
    dir_row_t dir_tab[$];
    in_item_t x;
    int       ph;
    rst_n         = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) tt_used[i] = 1'b0;

    dir_tab.insert(dir_tab.size(), drow(REQ_STOP, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b0,
                   32'h0, 32'h0, 32'h0, 32'h0, 1, 1'b1, KIND_ACK, 5'd0, 1'b0, 1'b0));
    // no parameter words given: all ones stored
    dir_tab.insert(dir_tab.size(), drow(REQ_SET, 16'h0000, 32'h1, 32'h0, 1'b0, 1'b0,
                   32'hDEAD_BEEF, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 1, 1'b1, KIND_ACK,
                   5'd0, 1'b0, 1'b0));
    dir_tab.insert(dir_tab.size(), drow(REQ_SET, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1, 1'b1,
                   KIND_ACK, 5'd0, 1'b0, 1'b0));
    dir_tab.insert(dir_tab.size(), drow(REQ_SET, 16'h0000, 32'h2, 32'h0, 1'b0, 1'b1,
                   32'h1, 32'h2, 32'h3, 32'h4, 1, 1'b1, KIND_ACK, 5'd0, 1'b1, 1'b0));
    // slot 0 fires, the other one has not wrapped past its interval
    dir_tab.insert(dir_tab.size(), drow(REQ_TICK, 16'h0000, 32'h0, 32'h3, 1'b0, 1'b0,
                   32'h0, 32'h0, 32'h0, 32'h0, 1, 1'b0, KIND_SUMMARY, 5'd0, 1'b0, 1'b0));
    dir_tab.insert(dir_tab.size(), drow(REQ_SET, 16'h1234, 32'h0, 32'h5, 1'b1, 1'b1,
                   32'h0, 32'h0, 32'h0, 32'h0, 1, 1'b1, KIND_ACK, 5'd0, 1'b0, 1'b0));
    dir_tab.insert(dir_tab.size(), drow(REQ_ACT, 16'hAAAA, 32'h0, 32'h0, 1'b1, 1'b0,
                   32'h0, 32'h0, 32'h0, 32'h0, 1, 1'b1, KIND_ACK, 5'd0, 1'b0, 1'b0));
    dir_tab.insert(dir_tab.size(), drow(REQ_SET, 16'h0000, 32'h0, 32'h7, 1'b0, 1'b0,
                   32'h0, 32'h0, 32'h0, 32'h0, 1, 1'b1, KIND_ACK, 5'd0, 1'b1, 1'b0));
    dir_tab.insert(dir_tab.size(), drow(REQ_ACT, 16'hFFFF, 32'h0, 32'h0, 1'b0, 1'b0,
                   32'h0, 32'h0, 32'h0, 32'h0, 1, 1'b1, KIND_ACK, 5'd0, 1'b1, 1'b0));
    // stopped active slot gets freed, inactive one skipped
    dir_tab.insert(dir_tab.size(), drow(REQ_TICK, 16'h0000, 32'h0, 32'hA, 1'b0, 1'b0,
                   32'h0, 32'h0, 32'h0, 32'h0, 1, 1'b1, KIND_SUMMARY, 5'd0, 1'b0, 1'b0));
    // fill every free slot
    dir_tab.insert(dir_tab.size(), drow(REQ_SET, 16'h8000, 32'h5, 32'h1000, 1'b0, 1'b1,
                   32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_FFFF, 32'hFFFF_0000, 15, 1'b1,
                   KIND_ACK, 5'd0, 1'b0, 1'b0));
    dir_tab.insert(dir_tab.size(), drow(REQ_SET, 16'hBEEF, 32'h7, 32'h1100, 1'b1, 1'b1,
                   32'h0, 32'h0, 32'h0, 32'h0, 1, 1'b1, KIND_ACK, 5'd0, 1'b0, 1'b1));
    dir_tab.insert(dir_tab.size(), drow(REQ_TICK, 16'h0000, 32'h0, 32'h2000, 1'b0, 1'b0,
                   32'h0, 32'h0, 32'h0, 32'h0, 1, 1'b0, KIND_SUMMARY, 5'd0, 1'b0, 1'b0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      for (int k = 0; k < dir_tab[r].rep; k++) begin
        x = dir_tab[r].item;
        x.timer_id = dir_tab[r].item.timer_id + 16'(k);
        send_word(x, dir_tab[r].typed, dir_tab[r].res);
      end
    end
    in_chan.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);

    // start near the wrap of the millisecond counter
    clock_ms = 32'hFFFF_F000;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 54;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 54;
          hold_len     = HOLD_CYCLES;
        end
        default: begin
          tx_idle_pct  = 18;
          rx_stall_pct = 18;
        end
      endcase
      foreach (id_pool[i]) id_pool[i] = 16'($urandom_range(65535));
      repeat (PHASE_WORDS) send_word(random_request(), 1'b0, '0);
    end
    in_chan.valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("interval_timer_table regression: pass");
    end else begin
      $display("interval_timer_table regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/itt_pkg.sv
hdl/itt_in_if.sv
hdl/itt_out_if.sv
hdl/itt_cell.sv
hdl/interval_timer_table.sv
sim/tb_top.sv
